>>> hw/rtl/actc_pkg.sv
// Shared types and constants for the bounded array table with compaction.
// Holds the request and result payloads, the operation codes and the
// command and status groups between the controller and the datapath.
package actc_pkg;

  localparam int unsigned KindW    = 3;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned IndexW   = 7;
  localparam int unsigned LengthW  = 8;
  localparam int unsigned DefDepth = 128;
  localparam int unsigned DefWidth = 32;

  typedef enum logic [KindW-1:0] {
    KIND_APPEND     = 3'd0,
    KIND_READ       = 3'd1,
    KIND_FIND       = 3'd2,
    KIND_REMOVE_AT  = 3'd3,
    KIND_REMOVE_ALL = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic [KindW-1:0]         kind;
    logic signed [ValueW-1:0] value;
    logic [IndexW-1:0]        index;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [ValueW-1:0] word;
    logic [IndexW-1:0]        position;
    logic [LengthW-1:0]       length;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic append;
    logic issue;
    logic commit;
    logic close;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             idx_ok;
    logic             more;
    logic             pv;
    logic             hit;
  } dp_status_t;

endpackage

>>> hw/rtl/actc_datapath.sv
// Datapath of the array table: entry memory, length counter, walk pointers
// and the result and output registers. Depends on actc_pkg.
module actc_datapath #(
  parameter int unsigned DEPTH = actc_pkg::DefDepth,
  parameter int unsigned WIDTH = actc_pkg::DefWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  actc_pkg::req_t         req_i,
  input  actc_pkg::dp_cmd_t      cmd_i,
  output actc_pkg::dp_status_t   status_o,
  output actc_pkg::rsp_t         rsp_o
);
  import actc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (CW > IndexW) ? CW : IndexW;

  logic [WIDTH-1:0] mem [DEPTH];

  logic [KindW-1:0]  kind_q, kind_d;
  logic [WIDTH-1:0]  val_q, val_d;
  logic [IndexW-1:0] idx_q, idx_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     rd_q, rd_d;
  logic [CW-1:0]     end_q, end_d;
  logic [CW-1:0]     wr_q, wr_d;
  logic              pv_q, pv_d;
  logic [AW-1:0]     pidx_q, pidx_d;
  logic [WIDTH-1:0]  rdata_q;
  logic              ok_q, ok_d;
  logic [ValueW-1:0] word_q, word_d;
  logic [IndexW-1:0] pos_q, pos_d;
  rsp_t              out_q, out_d;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WIDTH-1:0]  mem_wdata;
  logic [IW-1:0]     in_idx;
  logic [ValueW-1:0] in_val_u;
  logic [CW-1:0]     rd_start;
  logic [CW-1:0]     rd_end;
  logic              hit;
  logic              full;

  assign hit  = pv_q && (rdata_q == val_q);
  assign full = (cnt_q == CW'(DEPTH));

  always_comb begin
    in_idx   = IW'(req_i.index);
    in_val_u = req_i.value;
    rd_start = '0;
    rd_end   = cnt_q;
    case (kind_e'(req_i.kind))
      KIND_READ: begin
        rd_start = CW'(in_idx);
        rd_end   = CW'(in_idx + IW'(1));
      end
      KIND_FIND: begin
        rd_start = CW'(in_idx);
      end
      KIND_REMOVE_AT: begin
        rd_start = CW'(in_idx + IW'(1));
      end
      default: begin
        rd_start = '0;
      end
    endcase
  end

  always_comb begin
    kind_d    = kind_q;
    val_d     = val_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    rd_d      = rd_q;
    end_d     = end_q;
    wr_d      = wr_q;
    pv_d      = 1'b0;
    pidx_d    = pidx_q;
    ok_d      = ok_q;
    word_d    = word_q;
    pos_d     = pos_q;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = val_q;

    if (cmd_i.load) begin
      kind_d = req_i.kind;
      val_d  = WIDTH'(in_val_u);
      idx_d  = req_i.index;
      rd_d   = rd_start;
      end_d  = rd_end;
      wr_d   = '0;
      ok_d   = 1'b0;
      word_d = '0;
      pos_d  = '0;
    end

    if (cmd_i.append && !full) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_q[AW-1:0];
      mem_wdata = val_q;
      cnt_d     = cnt_q + CW'(1);
      ok_d      = 1'b1;
    end

    if (cmd_i.issue) begin
      pv_d   = 1'b1;
      pidx_d = rd_q[AW-1:0];
      rd_d   = rd_q + CW'(1);
    end

    if (cmd_i.commit) begin
      case (kind_e'(kind_q))
        KIND_READ: begin
          ok_d   = 1'b1;
          word_d = ValueW'(rdata_q);
        end
        KIND_FIND: begin
          if (hit) begin
            ok_d  = 1'b1;
            pos_d = IndexW'(pidx_q);
          end
        end
        KIND_REMOVE_AT: begin
          mem_we    = 1'b1;
          mem_waddr = pidx_q - AW'(1);
          mem_wdata = rdata_q;
        end
        KIND_REMOVE_ALL: begin
          if (!hit) begin
            mem_we    = 1'b1;
            mem_waddr = wr_q[AW-1:0];
            mem_wdata = rdata_q;
            wr_d      = wr_q + CW'(1);
          end
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end

    if (cmd_i.close) begin
      case (kind_e'(kind_q))
        KIND_REMOVE_AT: begin
          cnt_d = cnt_q - CW'(1);
          ok_d  = 1'b1;
        end
        KIND_REMOVE_ALL: begin
          cnt_d = wr_q;
          ok_d  = (wr_q != cnt_q);
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end

    if (cmd_i.emit) begin
      out_d.ok       = ok_q;
      out_d.word     = word_q;
      out_d.position = pos_q;
      out_d.length   = LengthW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pv_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      pv_q  <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    val_q  <= val_d;
    idx_q  <= idx_d;
    rd_q   <= rd_d;
    end_q  <= end_d;
    wr_q   <= wr_d;
    pidx_q <= pidx_d;
    ok_q   <= ok_d;
    word_q <= word_d;
    pos_q  <= pos_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.issue) begin
      rdata_q <= mem[rd_q[AW-1:0]];
    end
  end

  assign status_o.kind   = kind_q;
  assign status_o.idx_ok = (IW'(idx_q) < IW'(cnt_q));
  assign status_o.more   = (rd_q < end_q);
  assign status_o.pv     = pv_q;
  assign status_o.hit    = hit;
  assign rsp_o           = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_wr_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pv_q && (kind_q == KIND_REMOVE_ALL)) |-> (wr_q <= CW'(pidx_q)))
    else $error("Compaction write pointer passed the read pointer.");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.append && !full) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("Append did not increase the entry count.");

endmodule

>>> hw/rtl/actc_ctrl.sv
// Controller state machine of the array table: sequences request capture,
// the memory walk and the result transfer. Depends on actc_pkg.
module actc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  actc_pkg::dp_status_t status_i,
  output actc_pkg::dp_cmd_t    cmd_o
);
  import actc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        find_stop;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    find_stop  = (kind_e'(status_i.kind) == KIND_FIND) && status_i.hit;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        case (kind_e'(status_i.kind))
          KIND_APPEND: begin
            cmd_o.append = 1'b1;
            state_d      = ST_FIN;
          end
          KIND_READ, KIND_FIND, KIND_REMOVE_AT: begin
            state_d = status_i.idx_ok ? ST_WALK : ST_FIN;
          end
          KIND_REMOVE_ALL: begin
            state_d = ST_WALK;
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end
      ST_WALK: begin
        cmd_o.commit = status_i.pv;
        if (find_stop || (!status_i.more && !status_i.pv)) begin
          cmd_o.close = 1'b1;
          state_d     = ST_FIN;
        end else begin
          cmd_o.issue = status_i.more;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("Result overwrote a transfer still pending.");

  a_commit_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> status_i.pv)
    else $error("Commit issued without read data.");

  a_issue_fills_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |=> status_i.pv)
    else $error("Memory read did not produce pipeline data.");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_o)
    else $error("Result not presented after emit.");

endmodule

>>> hw/rtl/array_table_with_compaction.sv
// Bounded array table with append, read, find, remove-at and remove-all.
// Append, unknown kinds and requests other than remove-all whose index lies past the length
// go from capture straight to the result; a read, find or removal first walks the entries
// at one per cycle, and a find stops on a match. A full output register delays the result,
// and the next request is taken the cycle after the result enters it. Reset clears the
// length, the control state and the valid flags, not the entries or result registers.
module array_table_with_compaction #(
  parameter int unsigned DEPTH = actc_pkg::DefDepth,
  parameter int unsigned WIDTH = actc_pkg::DefWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  actc_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output actc_pkg::rsp_t   out_data_o
);
  import actc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  actc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  actc_datapath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (in_data_i),
    .cmd_i    (cmd),
    .status_o (status),
    .rsp_o    (out_data_o)
  );

endmodule

>>> tb/array_table_with_compaction_tb.sv
`timescale 1ns / 1ps
// Testbench for array_table_with_compaction. A shadow copy of the table predicts
// every result, and a monitor checks each output transfer field by field.
// It depends on actc_pkg for the payload structs and the operation codes.
module array_table_with_compaction_tb;
  import actc_pkg::*;

  localparam int unsigned Depth = DefDepth;
  localparam logic [KindW-1:0] KindUnusedLo = 3'd5;
  localparam logic [KindW-1:0] KindUnusedHi = 3'd7;
  localparam int unsigned RandItems = 1690;
  localparam int unsigned FillItems = 124;
  localparam int unsigned PoolSize = 6;
  localparam int unsigned PendMax = 4;
  localparam int unsigned HoldAt = 300;
  localparam int unsigned HoldOffLen = 400;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit = 3_000_000;

  typedef enum int {
    PH_FILL,
    PH_CHURN,
    PH_DRAIN
  } phase_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  logic [ValueW-1:0] entry_mem [Depth];
  int unsigned entry_cnt = 0;
  logic [ValueW-1:0] val_pool [PoolSize];

  req_t pend_q[$];
  rsp_t rsp_due_q[$];
  int unsigned fails = 0;
  int unsigned rsp_seen = 0;
  int unsigned queued = 0;
  int unsigned cycles = 0;

  array_table_with_compaction DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #1 clk = ~clk;

  function automatic rsp_t table_apply(req_t req);
    rsp_t rsp;
    logic [ValueW-1:0] key;
    int unsigned wr;
    rsp = '0;
    key = req.value;
    case (req.kind)
      KIND_APPEND: begin
        if (entry_cnt < Depth) begin
          entry_mem[entry_cnt] = key;
          entry_cnt++;
          rsp.ok = 1'b1;
        end
      end
      KIND_READ: begin
        if (req.index < entry_cnt) begin
          rsp.ok = 1'b1;
          rsp.word = entry_mem[req.index];
        end
      end
      KIND_FIND: begin
        for (int i = req.index; i < entry_cnt && !rsp.ok; i++) begin
          if (entry_mem[i] == key) begin
            rsp.ok = 1'b1;
            rsp.position = IndexW'(i);
          end
        end
      end
      KIND_REMOVE_AT: begin
        if (req.index < entry_cnt) begin
          for (int i = req.index; i + 1 < entry_cnt; i++) begin
            entry_mem[i] = entry_mem[i + 1];
          end
          entry_cnt--;
          rsp.ok = 1'b1;
        end
      end
      KIND_REMOVE_ALL: begin
        wr = 0;
        for (int i = 0; i < entry_cnt; i++) begin
          if (entry_mem[i] != key) begin
            entry_mem[wr] = entry_mem[i];
            wr++;
          end
        end
        rsp.ok = (wr != entry_cnt);
        entry_cnt = wr;
      end
      default: begin
      end
    endcase
    rsp.length = LengthW'(entry_cnt);
    return rsp;
  endfunction

  function automatic req_t random_req(phase_e ph);
    req_t req;
    int unsigned pick;
    int unsigned append_pct;
    int unsigned cnt;
    case (ph)
      PH_FILL:  append_pct = 75;
      PH_CHURN: append_pct = 35;
      default:  append_pct = 12;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      req.kind = KindW'($urandom_range(KindUnusedLo, KindUnusedHi));
    end else if (pick < append_pct) begin
      req.kind = KIND_APPEND;
    end else begin
      req.kind = KindW'($urandom_range(KIND_READ, KIND_REMOVE_ALL));
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      req.value = val_pool[$urandom_range(0, PoolSize - 1)];
    end else if (pick < 80) begin
      case ($urandom_range(0, 3))
        0:       req.value = 32'h8000_0000;
        1:       req.value = 32'h7fff_ffff;
        2:       req.value = '0;
        default: req.value = '1;
      endcase
    end else begin
      req.value = $urandom;
    end
    cnt = (entry_cnt > 127) ? 127 : entry_cnt;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      req.index = IndexW'($urandom_range(0, (cnt > 0) ? cnt - 1 : 0));
    end else if (pick < 75) begin
      req.index = IndexW'(cnt);
    end else begin
      req.index = IndexW'($urandom_range(0, 127));
    end
    return req;
  endfunction

  task automatic queue_req(input req_t req);
    while (pend_q.size() >= PendMax) @(negedge clk);
    pend_q.push_back(req);
    queued++;
  endtask

  task automatic queue_op(input logic [KindW-1:0] kind, input logic [ValueW-1:0] value,
                          input logic [IndexW-1:0] index);
    req_t req;
    req.kind = kind;
    req.value = value;
    req.index = index;
    queue_req(req);
  endtask

  // The sender offers items in bursts and predicts each result at its transfer.
  always @(posedge clk) begin
    int burst_left;
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        rsp_due_q.push_back(table_apply(in_data));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pend_q.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 140)
                                                    : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver alternates runs and stalls, and once holds off for a long time.
  always @(posedge clk) begin
    int run_left;
    int stall_left;
    int hold_left;
    bit held;
    if (!rst_n) begin
      out_ready <= 1'b0;
      run_left = 0;
      stall_left = 0;
      hold_left = 0;
      held = 1'b0;
    end else if (!held && rsp_seen >= HoldAt) begin
      held = 1'b1;
      hold_left = HoldOffLen;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      run_left = $urandom_range(1, 30);
      stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(0, 6);
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      rsp_seen <= rsp_seen + 1;
      if (rsp_due_q.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %p",
                 $time, out_data);
        fails++;
      end else begin
        want = rsp_due_q.pop_front();
        if (out_data.ok !== want.ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, want.ok, out_data.ok);
          fails++;
        end
        if (out_data.word !== want.word) begin
          $display("%0t: word expected %0d actual %0d", $time, want.word, out_data.word);
          fails++;
        end
        if (out_data.position !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time, want.position,
                   out_data.position);
          fails++;
        end
        if (out_data.length !== want.length) begin
          $display("%0t: length expected %0d actual %0d", $time, want.length,
                   out_data.length);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    phase_e ph;
    val_pool[0] = 32'd100;
    val_pool[1] = '1;
    val_pool[2] = 32'h8000_0000;
    val_pool[3] = 32'h7fff_ffff;
    val_pool[4] = '0;
    val_pool[5] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, extreme words, reads and finds around the length,
    // removals with and without a match, and the unused operation codes.
    queue_op(KIND_READ, '0, '0);
    queue_op(KIND_FIND, '0, '0);
    queue_op(KIND_REMOVE_AT, '0, '0);
    queue_op(KIND_REMOVE_ALL, '0, '0);
    queue_op(KIND_APPEND, 32'h8000_0000, '0);
    queue_op(KIND_APPEND, 32'h7fff_ffff, 7'd127);
    queue_op(KIND_APPEND, '0, '0);
    queue_op(KIND_APPEND, '1, '0);
    queue_op(KIND_APPEND, 32'd100, '0);
    queue_op(KIND_APPEND, 32'h7fff_ffff, '0);
    queue_op(KIND_READ, '0, '0);
    queue_op(KIND_READ, '0, 7'd4);
    queue_op(KIND_READ, '0, 7'd6);
    queue_op(KIND_READ, '1, 7'd127);
    queue_op(KIND_FIND, 32'h7fff_ffff, '0);
    queue_op(KIND_FIND, 32'h7fff_ffff, 7'd2);
    queue_op(KIND_FIND, '1, 7'd127);
    queue_op(KIND_FIND, 32'd12345, '0);
    queue_op(KIND_REMOVE_AT, '0, 7'd127);
    queue_op(KIND_REMOVE_AT, '0, '0);
    queue_op(KIND_REMOVE_ALL, 32'h7fff_ffff, '0);
    queue_op(KIND_REMOVE_ALL, 32'h7fff_ffff, '0);
    queue_op(KindUnusedLo, '0, '0);
    queue_op(KindUnusedHi, 32'd100, 7'd1);

    // The table now holds three entries. Fill it to the depth, try to append
    // past it, then work on the last slot.
    for (int i = 0; i < FillItems; i++) begin
      queue_op(KIND_APPEND, $urandom, '0);
    end
    queue_op(KIND_APPEND, 32'h7fff_ffff, '0);
    for (int i = 0; i < 5; i++) begin
      queue_op(KIND_APPEND, val_pool[i], '0);
    end
    queue_op(KIND_READ, '0, 7'd127);
    queue_op(KIND_FIND, 32'h7fff_ffff, 7'd127);
    queue_op(KIND_FIND, 32'd100, 7'd127);
    queue_op(KIND_REMOVE_AT, '0, 7'd127);
    queue_op(KIND_APPEND, 32'd100, '0);
    queue_op(KIND_APPEND, '1, '0);

    for (sent = 0; sent < RandItems; sent++) begin
      if (sent < RandItems / 3) begin
        ph = PH_FILL;
      end else if (sent < 2 * RandItems / 3) begin
        ph = PH_CHURN;
      end else begin
        ph = PH_DRAIN;
      end
      queue_req(random_req(ph));
    end

    while (pend_q.size() != 0 || in_valid || rsp_due_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (rsp_seen != queued) begin
      $display("%0t: result count expected %0d actual %0d", $time, queued, rsp_seen);
      fails++;
    end
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
